### hdl/rcfr_pkg.sv
package rcfr_pkg;

  localparam logic [7:0]  START_BYTE      = 8'h3E;
  localparam logic [7:0]  RC_TYPE_BYTE    = 8'h31;
  localparam logic [6:0]  MIN_FRAME_BYTES = 7'd7;
  localparam logic [6:0]  CHAN_OFFSET     = 7'd6;
  localparam logic [6:0]  LEN_POS         = 7'd2;
  localparam logic [6:0]  TYPE_POS        = 7'd4;
  localparam logic [15:0] JUNK_LIMIT_RST  = 16'd1000;
  localparam logic [15:0] JUNK_MAX        = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_TAKEN   = 3'd0,
    ST_JUNK    = 3'd1,
    ST_ACCEPT  = 3'd2,
    ST_CRCFAIL = 3'd3,
    ST_DROP    = 3'd4,
    ST_HUNT    = 3'd5
  } status_t;

  // Reflected CRC-16, one byte per call, table-free form.
  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ {d[3:0], 4'b0000};
    return {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b000};
  endfunction

endpackage

### hdl/rcfr_ram.sv
module rcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/rc_frame_receiver_crc16.sv
// Serial RC frame receiver with reflected CRC-16 check.
// in_*  : one received UART byte per item (in_tdata[7:0]).
// out_* : result items. tdata = status[2:0], channel_index[6:3],
//         channel_value[20:7]; tlast marks the final item caused by a byte.
// cfg_* : writes junk_limit (cfg_data[15:0]); always ready, use while idle.
// A byte is held in the input register and parsed there; its first result
// is then registered in the output register and shown on out_*. One byte
// per cycle is sustained while the result side keeps taking items and no
// channel or hunt item is due. A good frame end reads the channel store
// (two byte-wide RAMs, one entry per channel) in order: E_START starts the
// first read, then E_OUT gives one channel item per cycle while the result
// side takes them, and no new byte is parsed meanwhile. A junk or CRC
// failure that trips the baud hunt check adds a second item, ST_HUNT.
// The input register still takes one byte while parsing is held, and a
// finished result waits in the output register while the next byte enters.
// A stalled receiver holds the output item and, behind it, all parsing.
// Reset clears frame state, junk count and the store valid bits (the store
// reads as zero until written); junk_limit returns to 1000.
module rc_frame_receiver_crc16 #(
  parameter int NUM_CHANNELS    = 16,
  parameter int MAX_FRAME_BYTES = 70
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[2:0], channel_index[6:3], channel_value[20:7]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // junk_limit
);
  import rcfr_pkg::*;

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [AW-1:0] LAST_CH     = AW'(NUM_CHANNELS - 1);
  localparam logic [6:0]    STORE_BYTES = 7'(2 * NUM_CHANNELS);
  localparam logic [7:0]    MAX_LEN     = 8'(MAX_FRAME_BYTES);

  typedef enum logic [1:0] {E_IDLE, E_START, E_OUT} emit_state_t;

  logic              a_valid_r, a_valid_nxt;
  logic [7:0]        a_byte_r;
  logic              in_frame_r, in_frame_nxt;
  logic [6:0]        pos_r, pos_nxt;
  logic [6:0]        len_r, len_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [15:0]       jc_r, jc_nxt;
  logic              seen_r, seen_nxt;
  logic [15:0]       junk_limit_r;
  logic              hunt_pend_r, hunt_pend_nxt;
  emit_state_t       emit_r, emit_nxt;
  logic [AW-1:0]     emit_k_r, emit_k_nxt;
  logic [NUM_CHANNELS-1:0] vlo_r, vlo_nxt, vhi_r, vhi_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_st_r, out_st_nxt;
  logic [3:0]        out_idx_r, out_idx_nxt;
  logic [13:0]       out_val_r, out_val_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_free, a_adv, drop, fin, hunt;
  logic [6:0]        pos_cur, len_cur, st_idx, pos_inc;
  logic [15:0]       crc_cur, crc_new, jc_tmp;
  logic [16:0]       jc_sum, raw_sum;
  status_t           fin_st;
  logic              wr_en, wr_lo, wr_hi, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [7:0]        rd_lo, rd_hi, lo_m, hi_m;

  assign out_free  = !out_valid_r || out_tready;
  assign a_adv     = a_valid_r && !hunt_pend_r && (emit_r == E_IDLE) && out_free;
  assign in_tready = !a_valid_r || a_adv;
  assign cfg_ready = 1'b1;

  assign pos_cur = in_frame_r ? pos_r : 7'd0;
  assign crc_cur = in_frame_r ? crc_r : 16'd0;
  // the length byte counts for the byte that carries it
  assign len_cur = !in_frame_r ? MIN_FRAME_BYTES :
                   (pos_r == LEN_POS) ? a_byte_r[6:0] : len_r;

  assign crc_new = crc_next(crc_cur, a_byte_r);
  assign st_idx  = pos_cur - CHAN_OFFSET;
  assign wr_addr = st_idx[AW:1];
  assign wr_lo   = wr_en && !st_idx[0];
  assign wr_hi   = wr_en && st_idx[0];
  assign pos_inc = pos_cur + 7'd1;
  assign jc_sum  = {1'b0, jc_r} + {10'b0, len_cur};

  assign lo_m    = vlo_r[emit_k_r] ? rd_lo : 8'h00;
  assign hi_m    = vhi_r[emit_k_r] ? rd_hi : 8'h00;
  assign raw_sum = {1'b0, hi_m, lo_m} + 17'd4;

  always_comb begin
    a_valid_nxt   = a_valid_r;
    in_frame_nxt  = in_frame_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    crc_nxt       = crc_r;
    jc_nxt        = jc_r;
    seen_nxt      = seen_r;
    hunt_pend_nxt = hunt_pend_r;
    emit_nxt      = emit_r;
    emit_k_nxt    = emit_k_r;
    vlo_nxt       = vlo_r;
    vhi_nxt       = vhi_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    drop    = 1'b0;
    fin     = 1'b0;
    hunt    = 1'b0;
    fin_st  = ST_JUNK;
    jc_tmp  = jc_r;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = emit_k_r;

    if (in_tvalid && in_tready) begin
      a_valid_nxt = 1'b1;
    end else if (a_adv) begin
      a_valid_nxt = 1'b0;
    end

    if (a_adv) begin
      if (!in_frame_r && a_byte_r != START_BYTE) begin
        fin    = 1'b1;
        fin_st = ST_JUNK;
        jc_tmp = (jc_r == JUNK_MAX) ? jc_r : jc_r + 16'd1;
      end else begin
        if (in_frame_r && pos_r == LEN_POS &&
            (a_byte_r > MAX_LEN || a_byte_r < {1'b0, MIN_FRAME_BYTES})) begin
          drop = 1'b1;
        end
        if (in_frame_r && pos_r == TYPE_POS && a_byte_r != RC_TYPE_BYTE) begin
          drop = 1'b1;
        end
        if (drop) begin
          in_frame_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
          out_st_nxt    = ST_DROP;
          out_idx_nxt   = 4'd0;
          out_val_nxt   = 14'd0;
          out_last_nxt  = 1'b1;
        end else begin
          in_frame_nxt = 1'b1;
          wr_en        = (pos_cur >= CHAN_OFFSET) && (st_idx < STORE_BYTES);
          crc_nxt      = crc_new;
          pos_nxt      = pos_inc;
          len_nxt      = len_cur;
          if (pos_inc != len_cur) begin
            out_valid_nxt = 1'b1;
            out_st_nxt    = ST_TAKEN;
            out_idx_nxt   = 4'd0;
            out_val_nxt   = 14'd0;
            out_last_nxt  = 1'b1;
          end else begin
            in_frame_nxt = 1'b0;
            if (crc_new == 16'd0) begin
              seen_nxt = 1'b1;
              emit_nxt = E_START;
            end else begin
              fin    = 1'b1;
              fin_st = ST_CRCFAIL;
              jc_tmp = jc_sum[16] ? JUNK_MAX : jc_sum[15:0];
            end
          end
        end
      end

      if (fin) begin
        hunt          = !seen_r && (jc_tmp > junk_limit_r);
        jc_nxt        = hunt ? 16'd0 : jc_tmp;
        hunt_pend_nxt = hunt;
        out_valid_nxt = 1'b1;
        out_st_nxt    = fin_st;
        out_idx_nxt   = 4'd0;
        out_val_nxt   = 14'd0;
        out_last_nxt  = !hunt;
      end
    end else if (hunt_pend_r && out_free) begin
      hunt_pend_nxt = 1'b0;
      out_valid_nxt = 1'b1;
      out_st_nxt    = ST_HUNT;
      out_idx_nxt   = 4'd0;
      out_val_nxt   = 14'd0;
      out_last_nxt  = 1'b1;
    end else begin
      case (emit_r)
        E_START: begin
          rd_en      = 1'b1;
          rd_addr    = '0;
          emit_k_nxt = '0;
          emit_nxt   = E_OUT;
        end
        E_OUT: begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_st_nxt    = ST_ACCEPT;
            out_idx_nxt   = 4'(emit_k_r);
            out_val_nxt   = raw_sum[16:3];
            if (emit_k_r == LAST_CH) begin
              out_last_nxt = 1'b1;
              emit_nxt     = E_IDLE;
            end else begin
              out_last_nxt = 1'b0;
              emit_k_nxt   = emit_k_r + AW'(1);
              rd_en        = 1'b1;
              rd_addr      = emit_k_r + AW'(1);
            end
          end
        end
        default: ;
      endcase
    end

    if (wr_en && !st_idx[0]) begin
      vlo_nxt[wr_addr] = 1'b1;
    end
    if (wr_en && st_idx[0]) begin
      vhi_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r    <= 1'b0;
      in_frame_r   <= 1'b0;
      pos_r        <= 7'd0;
      len_r        <= MIN_FRAME_BYTES;
      crc_r        <= 16'd0;
      jc_r         <= 16'd0;
      seen_r       <= 1'b0;
      junk_limit_r <= JUNK_LIMIT_RST;
      hunt_pend_r  <= 1'b0;
      emit_r       <= E_IDLE;
      emit_k_r     <= '0;
      vlo_r        <= '0;
      vhi_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      a_valid_r    <= a_valid_nxt;
      in_frame_r   <= in_frame_nxt;
      pos_r        <= pos_nxt;
      len_r        <= len_nxt;
      crc_r        <= crc_nxt;
      jc_r         <= jc_nxt;
      seen_r       <= seen_nxt;
      hunt_pend_r  <= hunt_pend_nxt;
      emit_r       <= emit_nxt;
      emit_k_r     <= emit_k_nxt;
      vlo_r        <= vlo_nxt;
      vhi_r        <= vhi_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        junk_limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_byte_r <= in_tdata;
    end
    out_st_r   <= out_st_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  rcfr_ram #(.WIDTH(8), .DEPTH(NUM_CHANNELS), .AW(AW)) u_store_lo (
    .clk   (clk),
    .we    (wr_lo),
    .waddr (wr_addr),
    .wdata (a_byte_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_lo)
  );

  rcfr_ram #(.WIDTH(8), .DEPTH(NUM_CHANNELS), .AW(AW)) u_store_hi (
    .clk   (clk),
    .we    (wr_hi),
    .waddr (wr_addr),
    .wdata (a_byte_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_hi)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_val_r, out_idx_r, out_st_r};
  assign out_tlast  = out_last_r;

endmodule

### hdl/rcfr_chk.sv
module rcfr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);
  import rcfr_pkg::*;

  logic [2:0] st;
  assign st = out_tdata[2:0];

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // channel items of one frame come back to back in index order
  a_chan_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && st == ST_ACCEPT && !out_tlast |=>
      out_tvalid && out_tdata[2:0] == ST_ACCEPT &&
      out_tdata[6:3] == $past(out_tdata[6:3]) + 4'd1)
    else $error("channel items out of sequence");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_ACCEPT |-> out_tdata[20:3] == 18'd0)
    else $error("index or value set on a non-channel item");

  a_hunt_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_HUNT |-> out_tlast)
    else $error("baud hunt item not last");

endmodule

bind rc_frame_receiver_crc16 rcfr_chk u_rcfr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rcfr_pkg::*;

  localparam int NCH         = 16;
  localparam int MAX_LEN     = 70;
  localparam int STORE_LEN   = 2 * NCH;
  localparam int SETTLE      = 30;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct {
    status_t     st;
    logic [3:0]  chan;
    logic [13:0] value;
    logic        last;
  } rx_outcome_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = 16'h0000;

  // receiver mirror state
  logic        frm_open   = 1'b0;
  logic [6:0]  frm_pos    = 7'd0;
  logic [6:0]  frm_len    = MIN_FRAME_BYTES;
  logic [15:0] frm_crc    = 16'h0000;
  logic [7:0]  chan_bytes [STORE_LEN] = '{default: 8'h00};
  logic [15:0] junk_cnt   = 16'h0000;
  logic        good_seen  = 1'b0;
  logic [15:0] junk_limit_cfg = JUNK_LIMIT_RST;

  rx_outcome_t outcomes_due[$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          send_idle_pct;
  int          recv_idle_pct;

  rc_frame_receiver_crc16 #(
    .NUM_CHANNELS   (NCH),
    .MAX_FRAME_BYTES(MAX_LEN)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // rx_byte
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // status, channel_index, channel_value
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)    // junk_limit
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("rc_frame_receiver_crc16: mismatch");
    $finish;
  end

  // reflected poly 0x8408, bit-serial
  function automatic logic [15:0] kermit_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++)
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  function automatic void due(input status_t st, input logic [3:0] ch,
                              input logic [13:0] v, input logic l);
    rx_outcome_t o;
    o.st = st;
    o.chan = ch;
    o.value = v;
    o.last = l;
    outcomes_due.push_back(o);
  endfunction

  function automatic void close_junk(input status_t st);
    if (!good_seen && junk_cnt > junk_limit_cfg) begin
      junk_cnt = 16'h0000;
      due(st, 4'd0, 14'd0, 1'b0);
      due(ST_HUNT, 4'd0, 14'd0, 1'b1);
    end else begin
      due(st, 4'd0, 14'd0, 1'b1);
    end
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    int p;
    logic [16:0] raw;
    logic [16:0] sum;
    if (!frm_open) begin
      if (b != START_BYTE) begin
        if (junk_cnt != JUNK_MAX) junk_cnt = junk_cnt + 16'd1;
        close_junk(ST_JUNK);
        return;
      end
      frm_open = 1'b1;
      frm_pos = 7'd0;
      frm_len = MIN_FRAME_BYTES;
      frm_crc = 16'h0000;
    end else if (frm_pos == LEN_POS) begin
      if (int'(b) > MAX_LEN || int'(b) < int'(MIN_FRAME_BYTES)) begin
        frm_open = 1'b0;
        due(ST_DROP, 4'd0, 14'd0, 1'b1);
        return;
      end
      frm_len = b[6:0];
    end else if (frm_pos == TYPE_POS && b != RC_TYPE_BYTE) begin
      frm_open = 1'b0;
      due(ST_DROP, 4'd0, 14'd0, 1'b1);
      return;
    end

    p = int'(frm_pos) - int'(CHAN_OFFSET);
    if (p >= 0 && p < STORE_LEN) chan_bytes[p] = b;
    frm_crc = kermit_step(frm_crc, b);
    frm_pos = frm_pos + 7'd1;
    if (frm_pos != frm_len) begin
      due(ST_TAKEN, 4'd0, 14'd0, 1'b1);
      return;
    end

    frm_open = 1'b0;
    if (frm_crc == 16'h0000) begin
      good_seen = 1'b1;
      for (int k = 0; k < NCH; k++) begin
        raw = {1'b0, chan_bytes[2 * k + 1], chan_bytes[2 * k]} + 17'd4;
        due(ST_ACCEPT, 4'(k), raw[16:3], k == NCH - 1);
      end
    end else begin
      sum = {1'b0, junk_cnt} + {10'd0, frm_len};
      junk_cnt = sum[16] ? JUNK_MAX : sum[15:0];
      close_junk(ST_CRCFAIL);
    end
  endfunction

  // result side: check accepted items, then pick next cycle's ready
  always @(posedge clk) begin : result_check
    rx_outcome_t exp_o;
    if (rst_n && out_tvalid && out_tready) begin
      if (outcomes_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: st=%0d ch=%0d val=%0d last=%0b",
                   out_tdata[2:0], out_tdata[6:3], out_tdata[20:7], out_tlast);
        mismatches++;
      end else begin
        exp_o = outcomes_due.pop_front();
        if (out_tdata[2:0] !== exp_o.st || out_tdata[6:3] !== exp_o.chan ||
            out_tdata[20:7] !== exp_o.value || out_tlast !== exp_o.last) begin
          if (mismatches < 10)
            $display("exp st=%0d ch=%0d val=%0d last=%0b, got st=%0d ch=%0d val=%0d last=%0b",
                     exp_o.st, exp_o.chan, exp_o.value, exp_o.last,
                     out_tdata[2:0], out_tdata[6:3], out_tdata[20:7], out_tlast);
          mismatches++;
        end
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // tvalid stays high after a handshake so back-to-back items need no toggle
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  // must be called in the step of the last handshake
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_junk_limit(input logic [15:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    junk_limit_cfg = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == START_BYTE) b = ~b;
    return b;
  endfunction

  // fill < 0: random payload; CRC appended low byte first
  task automatic send_frame(input int len, input bit bad_crc, input int fill);
    logic [7:0]  fb[$];
    logic [15:0] c;
    fb.push_back(START_BYTE);
    fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back(8'(len));
    fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back(RC_TYPE_BYTE);
    while (fb.size() < len - 2)
      fb.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
    c = 16'h0000;
    foreach (fb[i]) c = kermit_step(c, fb[i]);
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    if (bad_crc) fb[len - 1] = fb[len - 1] ^ (8'h01 << $urandom_range(0, 7));
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  task automatic send_len_drop(input logic [7:0] len_byte);
    send_byte(START_BYTE);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(len_byte);
  endtask

  task automatic send_type_drop();
    logic [7:0] t;
    t = 8'($urandom_range(0, 255));
    if (t == RC_TYPE_BYTE) t = ~t;
    send_byte(START_BYTE);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(MIN_FRAME_BYTES, MAX_LEN)));
    send_byte(8'($urandom_range(0, 255)));
    send_byte(t);
  endtask

  // all hunt checks must run before the first good frame
  task automatic test_junk_hunt();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(noise_byte());
    write_junk_limit(16'd0);
    send_byte(noise_byte());
    write_junk_limit(16'd5);
    repeat (6) send_byte(noise_byte());
    write_junk_limit(16'd3);
    send_len_drop(8'd6);
    send_type_drop();
    send_frame(7, 1'b1, -1);
  endtask

  task automatic test_frames();
    send_frame(7, 1'b0, -1);
    send_frame(MAX_LEN, 1'b0, 8'hFF);
    send_frame(12, 1'b1, -1);
    send_len_drop(8'd6);
    send_len_drop(8'(MAX_LEN + 1));
    send_type_drop();
    send_frame(8, 1'b0, 8'h00);
    write_junk_limit(16'd0);
    send_byte(8'h00);
    send_frame(9, 1'b1, -1);
  endtask

  task automatic run_random_traffic(input int n_bytes);
    int first;
    int r;
    int len;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, MAX_LEN) : $urandom_range(7, 12);
      if (r < 55)
        send_frame(len, 1'b0, -1);
      else if (r < 68)
        send_frame(len, 1'b1, -1);
      else if (r < 76)
        send_len_drop($urandom_range(0, 1) ? 8'($urandom_range(0, 6))
                                           : 8'($urandom_range(MAX_LEN + 1, 255)));
      else if (r < 82)
        send_type_drop();
      else if (r < 94)
        repeat ($urandom_range(1, 3)) send_byte(noise_byte());
      else begin
        // truncated frame: following bytes get parsed as its tail
        send_byte(START_BYTE);
        repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    send_idle_pct = 38;
    recv_idle_pct = 57;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_junk_hunt();
    test_frames();
    run_random_traffic(8);

    write_junk_limit(16'hFFFF);
    send_idle_pct = 57;
    recv_idle_pct = 38;
    run_random_traffic(8);

    write_junk_limit(16'($urandom_range(0, 65535)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_traffic(8);

    drain_results();
    if (mismatches == 0)
      $display("rc_frame_receiver_crc16: match");
    else
      $display("rc_frame_receiver_crc16: mismatch");
    $finish;
  end

endmodule

### sim.f
hdl/rcfr_pkg.sv
hdl/rcfr_ram.sv
hdl/rc_frame_receiver_crc16.sv
hdl/rcfr_chk.sv
tb/testbench.sv
